// ----- hdl/cts_pkg.sv -----
// ----------------------------------------------------------------------------
// Cosine top-k search package
// Shared sizes, status codes, register indexes and the ranked-entry type.
// ----------------------------------------------------------------------------
package cts_pkg;

	localparam int MAX_ITEMS = 1024;
	localparam int MAX_DIM   = 256;
	localparam int MAX_TOP_K = 16;

	localparam int ITEM_W  = 10;
	localparam int CNT_W   = 11;
	localparam int DIM_W   = 8;
	localparam int POS_W   = 9;
	localparam int K_W     = 5;
	localparam int ELEM_W  = 16;
	localparam int NORM_W  = 40;
	localparam int DOT_W   = 40;
	localparam int SCORE_W = 16;

	typedef logic [2:0] status_t;
	localparam status_t ST_APPENDED   = 3'd0;
	localparam status_t ST_LEN_REJECT = 3'd1;
	localparam status_t ST_FULL       = 3'd2;
	localparam status_t ST_MATCH      = 3'd3;
	localparam status_t ST_NONE       = 3'd4;

	localparam logic CFG_VECTOR_LENGTH = 1'b0;
	localparam logic CFG_TOP_K         = 1'b1;

	typedef struct packed {
		logic                valid;
		logic [SCORE_W-1:0] score;
		logic [ITEM_W-1:0]  idx;
	} cts_entry_t;

endpackage

// ----- hdl/cosine_top_k_search.sv -----
// ----------------------------------------------------------------------------
// Cosine top-k search
// Vector store with exhaustive cosine-similarity search and a ranked list of
// the best matches held in a chain of cells.
// ----------------------------------------------------------------------------
// Elements are taken one per cycle while busy is low; an append result
// follows in the cycle after the final element. A query scans each stored
// vector with a pipelined dot product and the score unit (which skips its
// multiply and root steps for a zero-norm vector), then emits the ranked
// matches one per cycle. busy is high from a searching query's final element
// until its last result. Reset clears the counts and list, not the stores.
module cosine_top_k_search (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       kind,
	input  logic [cts_pkg::ELEM_W-1:0]  element_value,
	input  logic                       last,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [cts_pkg::POS_W-1:0]   cfg_wdata,
	output logic                       done,
	output logic [2:0]                 status,
	output logic [cts_pkg::ITEM_W-1:0]  item_index,
	output logic [cts_pkg::SCORE_W-1:0] score,
	output logic                       last_result
);
	import cts_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_DOT, S_SCORE, S_OUT} state_t;

	state_t             state_q;
	logic [POS_W-1:0]   vlen_q;
	logic [K_W-1:0]     topk_q;
	logic               kind_q;
	logic [POS_W-1:0]   pos_q;
	logic [NORM_W-1:0]  sum_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   item_q;
	logic [POS_W-1:0]   d_q;
	logic [POS_W-1:0]   len_q;
	logic [K_W-1:0]     limit_q;
	logic [NORM_W-1:0]  nq_q;
	logic [NORM_W-1:0]  nv_q;
	logic [3:0]         out_q;
	logic               rd_s1, mul_s2;
	logic signed [ELEM_W-1:0]   vec_s1, qry_s1;
	logic signed [2*ELEM_W-1:0] prod_s2;
	logic [DOT_W-1:0]   acc_q;

	logic signed [ELEM_W-1:0] vec_mem [MAX_ITEMS*MAX_DIM];
	logic signed [ELEM_W-1:0] qry_mem [MAX_DIM];
	logic [NORM_W-1:0]        norm_mem [MAX_ITEMS];

	logic               accept, sw, len_ok, full, in_store, append_ok, bad_query, clr;
	logic [POS_W-1:0]   eff_pos, next_pos;
	logic [NORM_W-1:0]  eff_sum, new_sum;
	logic signed [2*ELEM_W-1:0] sq;
	logic [K_W-1:0]     lim_a, lim;
	logic               dot_done, sc_done;
	logic [SCORE_W-1:0] sc_val;
	cts_entry_t         new_e, sel_e;
	cts_entry_t         chain_e [MAX_TOP_K+1];
	logic [MAX_TOP_K:0] ins_v;

	assign busy      = state_q != S_IDLE;
	assign accept    = start && !busy;
	assign sw        = (pos_q != '0) && (kind != kind_q);
	assign eff_pos   = sw ? '0 : pos_q;
	assign eff_sum   = sw ? '0 : sum_q;
	assign sq        = $signed(element_value) * $signed(element_value);
	assign new_sum   = eff_sum + NORM_W'(unsigned'(sq));
	assign next_pos  = (eff_pos <= POS_W'(MAX_DIM)) ? eff_pos + POS_W'(1) : eff_pos;
	assign len_ok    = (vlen_q != '0) && (vlen_q <= POS_W'(MAX_DIM)) && (next_pos == vlen_q);
	assign full      = count_q >= CNT_W'(MAX_ITEMS);
	assign in_store  = eff_pos < POS_W'(MAX_DIM);
	assign append_ok = accept && !kind && last && len_ok && !full;
	assign bad_query = !len_ok || (count_q == '0) || (topk_q == '0) || (new_sum == '0);
	assign clr       = accept && kind && last;
	assign lim_a     = (topk_q > K_W'(MAX_TOP_K)) ? K_W'(MAX_TOP_K) : topk_q;
	assign lim       = (CNT_W'(lim_a) > count_q) ? count_q[K_W-1:0] : lim_a;
	assign dot_done  = (state_q == S_DOT) && (d_q == len_q) && !rd_s1 && !mul_s2;

	always_ff @(posedge clk) begin
		if (accept && !kind && in_store && !full) begin
			vec_mem[{count_q[ITEM_W-1:0], eff_pos[DIM_W-1:0]}] <= element_value;
		end
		vec_s1 <= vec_mem[{item_q[ITEM_W-1:0], d_q[DIM_W-1:0]}];
	end

	always_ff @(posedge clk) begin
		if (accept && kind && in_store) begin
			qry_mem[eff_pos[DIM_W-1:0]] <= element_value;
		end
		qry_s1 <= qry_mem[d_q[DIM_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (append_ok) begin
			norm_mem[count_q[ITEM_W-1:0]] <= new_sum;
		end
		nv_q <= norm_mem[item_q[ITEM_W-1:0]];
	end

	cts_score u_score (
		.clk   (clk),
		.arst_n(arst_n),
		.start (dot_done),
		.dot   (acc_q),
		.nq    (nq_q),
		.nv    (nv_q),
		.done  (sc_done),
		.score (sc_val)
	);

	assign new_e      = '{valid: 1'b1, score: sc_val, idx: item_q[ITEM_W-1:0]};
	assign chain_e[0] = '0;
	assign ins_v[0]   = 1'b0;

	for (genvar j = 0; j < MAX_TOP_K; j++) begin : g_cell
		cts_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.clr     (clr),
			.en      (sc_done),
			.act     (K_W'(j) < limit_q),
			.new_e   (new_e),
			.prev_ins(ins_v[j]),
			.prev_e  (chain_e[j]),
			.ins     (ins_v[j+1]),
			.cur_e   (chain_e[j+1])
		);
	end

	assign sel_e = chain_e[{1'b0, out_q} + 5'd1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vlen_q  <= POS_W'(MAX_DIM);
			topk_q  <= K_W'(4);
			kind_q  <= 1'b0;
			pos_q   <= '0;
			sum_q   <= '0;
			count_q <= '0;
			rd_s1   <= 1'b0;
			mul_s2  <= 1'b0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_VECTOR_LENGTH: vlen_q <= cfg_wdata;
					CFG_TOP_K:         topk_q <= cfg_wdata[K_W-1:0];
				endcase
			end
			if (accept) begin
				kind_q <= kind;
				if (last) begin
					pos_q       <= '0;
					sum_q       <= '0;
					item_index  <= '0;
					score       <= '0;
					last_result <= 1'b1;
					if (!kind) begin
						done <= 1'b1;
						if (!len_ok) begin
							status <= ST_LEN_REJECT;
						end else if (full) begin
							status <= ST_FULL;
						end else begin
							status     <= ST_APPENDED;
							item_index <= count_q[ITEM_W-1:0];
							count_q    <= count_q + CNT_W'(1);
						end
					end else if (bad_query) begin
						done   <= 1'b1;
						status <= ST_NONE;
					end else begin
						state_q <= S_DOT;
						item_q  <= '0;
						d_q     <= '0;
						acc_q   <= '0;
						rd_s1   <= 1'b0;
						mul_s2  <= 1'b0;
						limit_q <= lim;
						nq_q    <= new_sum;
						len_q   <= vlen_q;
					end
				end else begin
					pos_q <= next_pos;
					sum_q <= new_sum;
				end
			end
			unique case (state_q)
				S_IDLE: begin
				end
				S_DOT: begin
					if (d_q != len_q) d_q <= d_q + POS_W'(1);
					rd_s1   <= d_q != len_q;
					mul_s2  <= rd_s1;
					prod_s2 <= vec_s1 * qry_s1;
					if (mul_s2) acc_q <= acc_q + DOT_W'(prod_s2);
					if (dot_done) state_q <= S_SCORE;
				end
				S_SCORE: begin
					if (sc_done) begin
						if (item_q + CNT_W'(1) == count_q) begin
							out_q   <= '0;
							state_q <= S_OUT;
						end else begin
							item_q  <= item_q + CNT_W'(1);
							d_q     <= '0;
							acc_q   <= '0;
							state_q <= S_DOT;
						end
					end
				end
				S_OUT: begin
					done        <= 1'b1;
					status      <= ST_MATCH;
					item_index  <= sel_e.idx;
					score       <= sel_e.score;
					last_result <= ({1'b0, out_q} + K_W'(1)) == limit_q;
					if (({1'b0, out_q} + K_W'(1)) == limit_q) begin
						state_q <= S_IDLE;
					end else begin
						out_q <= out_q + 4'd1;
					end
				end
			endcase
		end
	end

endmodule

// ----- hdl/cts_cell.sv -----
// ----------------------------------------------------------------------------
// Ranked list cell
// One place of the sorted best-match list; shifts down toward its neighbor
// when a better candidate is inserted above it.
// ----------------------------------------------------------------------------
module cts_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clr,
	input  logic              en,
	input  logic              act,
	input  cts_pkg::cts_entry_t new_e,
	input  logic              prev_ins,
	input  cts_pkg::cts_entry_t prev_e,
	output logic              ins,
	output cts_pkg::cts_entry_t cur_e
);
	import cts_pkg::*;

	logic               valid_q;
	logic [SCORE_W-1:0] score_q;
	logic [ITEM_W-1:0]  idx_q;

	assign ins   = act && (!valid_q || ($signed(new_e.score) > $signed(score_q)));
	assign cur_e = '{valid: valid_q, score: score_q, idx: idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clr) begin
			valid_q <= 1'b0;
		end else if (en && act) begin
			if (prev_ins) begin
				valid_q <= prev_e.valid;
			end else if (ins) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && act) begin
			if (prev_ins) begin
				score_q <= prev_e.score;
				idx_q   <= prev_e.idx;
			end else if (ins) begin
				score_q <= new_e.score;
				idx_q   <= new_e.idx;
			end
		end
	end

endmodule

// ----- hdl/cts_score.sv -----
// ----------------------------------------------------------------------------
// Cosine score unit
// Squares the dot product and multiplies the norms bit-serially, then finds
// the Q1.15 cosine one result bit per cycle by comparing squares.
// ----------------------------------------------------------------------------
module cts_score (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [cts_pkg::DOT_W-1:0]  dot,
	input  logic [cts_pkg::NORM_W-1:0] nq,
	input  logic [cts_pkg::NORM_W-1:0] nv,
	output logic                      done,
	output logic [cts_pkg::SCORE_W-1:0] score
);
	import cts_pkg::*;

	localparam int PROD_W = 2 * NORM_W;
	localparam int D_W    = PROD_W + 30;
	localparam int S_W    = PROD_W + 16;

	typedef enum logic [1:0] {U_IDLE, U_MUL, U_ROOT} ustate_t;

	ustate_t            state_q;
	logic               neg_q;
	logic [5:0]         cnt_q;
	logic [PROD_W-1:0]  mca_q, mcb_q, pa_q, pb_q;
	logic [NORM_W-1:0]  mpa_q, mpb_q;
	logic [3:0]         bit_q;
	logic [D_W-1:0]     r_q;
	logic [S_W-1:0]     s_q;
	logic [16:0]        lo_q;

	logic [DOT_W-1:0]   mag;
	logic [D_W:0]       cand;
	logic [D_W:0]       dref;
	logic               take;
	logic [16:0]        lo_next;
	logic [16:0]        lo_neg;

	assign mag     = dot[DOT_W-1] ? (~dot + DOT_W'(1)) : dot;
	assign dref    = {1'b0, pa_q, 30'b0};
	assign cand    = {1'b0, r_q} + ((D_W+1)'(s_q) << ({1'b0, bit_q} + 5'd1))
		+ ((D_W+1)'(pb_q) << {bit_q, 1'b0});
	assign take    = cand <= dref;
	assign lo_next = take ? (lo_q | (17'd1 << bit_q)) : lo_q;
	assign lo_neg  = ~lo_next + 17'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				U_IDLE: begin
					if (start) begin
						if (nv == '0) begin
							done  <= 1'b1;
							score <= '0;
						end else begin
							neg_q   <= dot[DOT_W-1];
							mca_q   <= PROD_W'(mag);
							mpa_q   <= mag;
							pa_q    <= '0;
							mcb_q   <= PROD_W'(nq);
							mpb_q   <= nv;
							pb_q    <= '0;
							cnt_q   <= 6'(NORM_W - 1);
							state_q <= U_MUL;
						end
					end
				end
				U_MUL: begin
					if (mpa_q[0]) pa_q <= pa_q + mca_q;
					if (mpb_q[0]) pb_q <= pb_q + mcb_q;
					mca_q <= mca_q << 1;
					mcb_q <= mcb_q << 1;
					mpa_q <= mpa_q >> 1;
					mpb_q <= mpb_q >> 1;
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == '0) begin
						r_q     <= '0;
						s_q     <= '0;
						lo_q    <= '0;
						bit_q   <= 4'd15;
						state_q <= U_ROOT;
					end
				end
				U_ROOT: begin
					if (take) begin
						r_q <= cand[D_W-1:0];
						s_q <= s_q + (S_W'(pb_q) << bit_q);
					end
					lo_q  <= lo_next;
					bit_q <= bit_q - 4'd1;
					if (bit_q == '0) begin
						done    <= 1'b1;
						state_q <= U_IDLE;
						if (neg_q) begin
							score <= lo_neg[SCORE_W-1:0];
						end else if (lo_next > 17'd32767) begin
							score <= 16'h7fff;
						end else begin
							score <= lo_next[SCORE_W-1:0];
						end
					end
				end
			endcase
		end
	end

endmodule

// ----- hdl/cts_checker.sv -----
// ----------------------------------------------------------------------------
// Cosine top-k search checker
// Watches the top-level ports for result ordering and result framing.
// ----------------------------------------------------------------------------
module cts_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       kind,
	input logic                       last,
	input logic                       done,
	input logic [2:0]                 status,
	input logic [cts_pkg::ITEM_W-1:0]  item_index,
	input logic [cts_pkg::SCORE_W-1:0] score,
	input logic                       last_result
);
	import cts_pkg::*;

	a_append_reply: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !kind && last |=> done && last_result &&
		(status == ST_APPENDED || status == ST_LEN_REJECT || status == ST_FULL))
		else $error("append word without a single reply");

	a_single_word: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_MATCH |-> last_result)
		else $error("non-match result is not final");

	a_none_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_NONE |-> score == '0 && item_index == '0)
		else $error("no-result word carries data");

	a_descending: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_MATCH && !last_result |=>
		done && status == ST_MATCH && ($signed(score) <= $signed($past(score))))
		else $error("matches out of order");

endmodule

bind cosine_top_k_search cts_checker u_cts_checker (.*);

// ----- dv/cts_checker.sv -----
// ----------------------------------------------------------------------------
// Cosine top-k search checker
// Watches the element and result ports, keeps its own copy of the vector
// store, works out the expected results of each accepted word and compares
// every result word field by field against them.
// ----------------------------------------------------------------------------
module cts_scoreboard
	import cts_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  logic                kind,
	input  logic [ELEM_W-1:0]   element_value,
	input  logic                last,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [POS_W-1:0]    cfg_wdata,
	input  logic                done,
	input  logic [2:0]          status,
	input  logic [ITEM_W-1:0]   item_index,
	input  logic [SCORE_W-1:0]  score,
	input  logic                last_result,
	output int                  errors,
	output int                  pending,
	output int                  n_appends,
	output int                  n_matches,
	output int                  n_refused
);

	typedef struct packed {
		status_t            st;
		logic [ITEM_W-1:0]  idx;
		logic [SCORE_W-1:0] sc;
		logic               lr;
	} result_word_t;

	result_word_t              want_q[$];
	logic signed [ELEM_W-1:0]  vec_mem [0:MAX_ITEMS-1][0:MAX_DIM-1];
	logic [NORM_W-1:0]         norm_mem [0:MAX_ITEMS-1];
	logic signed [ELEM_W-1:0]  qry_mem [0:MAX_DIM-1];
	int                        n_stored;
	int                        elem_pos;
	logic [NORM_W-1:0]         sq_sum;
	logic                      cur_kind;
	int                        vec_len;
	int                        k_cfg;

	function automatic logic signed [SCORE_W-1:0] cosine_q15(longint dot,
			logic [NORM_W-1:0] nq, logic [NORM_W-1:0] nv);
		logic [63:0]  mag;
		logic [127:0] rhs;
		logic [127:0] lhs;
		int           lo;
		int           hi;
		int           mid;
		if (nv == 0)
			return 0;
		mag = (dot < 0) ? 64'(-dot) : 64'(dot);
		rhs = (128'(mag) * 128'(mag)) << 30;
		lo = 0;
		hi = 32768;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			lhs = 128'(nq) * 128'(nv) * 128'(mid) * 128'(mid);
			if (lhs <= rhs)
				lo = mid;
			else
				hi = mid - 1;
		end
		if (dot < 0)
			return -lo;
		return (lo > 32767) ? 16'sd32767 : 16'(lo);
	endfunction

	function automatic void push_word(status_t st, int idx, int sc, logic lr);
		result_word_t w;
		w.st  = st;
		w.idx = ITEM_W'(idx);
		w.sc  = SCORE_W'(sc);
		w.lr  = lr;
		want_q.insert(want_q.size(), w);
	endfunction

	function automatic void rank_query(bit len_ok);
		int                       limit;
		int                       cnt;
		int                       p;
		int                       j;
		longint                   dot;
		logic signed [SCORE_W-1:0] sc;
		logic signed [SCORE_W-1:0] best_sc [MAX_TOP_K];
		int                       best_ix [MAX_TOP_K];
		cnt = 0;
		if (!len_ok || n_stored == 0 || k_cfg == 0 || sq_sum == 0) begin
			push_word(ST_NONE, 0, 0, 1'b1);
			return;
		end
		limit = (k_cfg > MAX_TOP_K) ? MAX_TOP_K : k_cfg;
		if (limit > n_stored)
			limit = n_stored;
		for (int i = 0; i < n_stored; i++) begin
			dot = 0;
			for (int d = 0; d < vec_len; d++)
				dot += longint'(qry_mem[d]) * longint'(vec_mem[i][d]);
			sc = cosine_q15(dot, sq_sum, norm_mem[i]);
			p = cnt;
			while (p > 0 && best_sc[p-1] < sc)
				p--;
			if (p < limit) begin
				j = (cnt < limit) ? cnt : limit - 1;
				for (; j > p; j--) begin
					best_sc[j] = best_sc[j-1];
					best_ix[j] = best_ix[j-1];
				end
				best_sc[p] = sc;
				best_ix[p] = i;
				if (cnt < limit)
					cnt++;
			end
		end
		for (int i = 0; i < cnt; i++)
			push_word(ST_MATCH, best_ix[i], best_sc[i], i + 1 == cnt);
	endfunction

	function automatic void take_word(logic k, logic signed [ELEM_W-1:0] e, logic l);
		bit len_ok;
		if (elem_pos != 0 && k != cur_kind) begin
			elem_pos = 0;
			sq_sum = '0;
		end
		cur_kind = k;
		if (elem_pos < MAX_DIM) begin
			if (k)
				qry_mem[elem_pos] = e;
			else if (n_stored < MAX_ITEMS)
				vec_mem[n_stored][elem_pos] = e;
		end
		sq_sum = sq_sum + NORM_W'(longint'(e) * longint'(e));
		if (elem_pos <= MAX_DIM)
			elem_pos++;
		if (!l)
			return;
		len_ok = vec_len >= 1 && vec_len <= MAX_DIM && elem_pos == vec_len;
		if (k)
			rank_query(len_ok);
		else if (!len_ok)
			push_word(ST_LEN_REJECT, 0, 0, 1'b1);
		else if (n_stored >= MAX_ITEMS)
			push_word(ST_FULL, 0, 0, 1'b1);
		else begin
			norm_mem[n_stored] = sq_sum;
			push_word(ST_APPENDED, n_stored, 0, 1'b1);
			n_stored++;
		end
		elem_pos = 0;
		sq_sum = '0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_word_t w;
		if (!arst_n) begin
			want_q.delete();
			n_stored = 0;
			elem_pos = 0;
			sq_sum = '0;
			cur_kind = 1'b0;
			vec_len = MAX_DIM;
			k_cfg = 4;
			errors = 0;
			pending = 0;
			n_appends = 0;
			n_matches = 0;
			n_refused = 0;
		end else begin
			if (done) begin
				if (want_q.size() == 0) begin
					$display("%0t: unexpected result word status %0d idx %0d score %0d",
						$time, status, item_index, $signed(score));
					errors++;
				end else begin
					w = want_q.pop_front();
					if (status != w.st || item_index != w.idx || score != w.sc ||
							last_result != w.lr) begin
						$display("%0t: expected status %0d idx %0d score %0d last %0d, got %0d %0d %0d %0d",
							$time, w.st, w.idx, $signed(w.sc), w.lr,
							status, item_index, $signed(score), last_result);
						errors++;
					end
					case (w.st)
						ST_APPENDED: n_appends++;
						ST_MATCH:    n_matches++;
						default:     n_refused++;
					endcase
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_VECTOR_LENGTH)
					vec_len = int'(cfg_wdata);
				else
					k_cfg = int'(cfg_wdata[K_W-1:0]);
			end
			if (start && !busy)
				take_word(kind, $signed(element_value), last);
			pending = want_q.size();
		end
	end

endmodule

// ----- dv/tb_cosine_top_k_search.sv -----
// ----------------------------------------------------------------------------
// Cosine top-k search testbench
// Drives append and query vectors through a few register settings, from the
// reset settings down to short vectors with random content and lengths.
// A separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_cosine_top_k_search;
	import cts_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                kind;
	logic [ELEM_W-1:0]   element_value;
	logic                last;
	logic                cfg_we;
	logic                cfg_index;
	logic [POS_W-1:0]    cfg_wdata;
	logic                done;
	logic [2:0]          status;
	logic [ITEM_W-1:0]   item_index;
	logic [SCORE_W-1:0]  score;
	logic                last_result;
	int                  errors;
	int                  pending;
	int                  n_appends;
	int                  n_matches;
	int                  n_refused;

	logic [ELEM_W-1:0]   vec_q[$];
	logic [ELEM_W-1:0]   saved_q[$];
	bit                  calm;
	int                  n_words;
	int                  quiet_cycles;
	int                  cur_len;

	cosine_top_k_search dut (.*);

	cts_scoreboard u_checker (.*);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 300000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic logic [ELEM_W-1:0] pick_elem();
		case ($urandom_range(9))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return 16'h0000;
			3:       return 16'(($urandom_range(1) != 0) ? 1 : -1);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_word(logic k, logic [ELEM_W-1:0] e, logic l);
		while (!calm && $urandom_range(99) < 24) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		kind <= k;
		element_value <= e;
		last <= l;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		n_words++;
	endtask

	task automatic send_vec(logic k);
		for (int i = 0; i < vec_q.size(); i++)
			send_word(k, vec_q[i], i == vec_q.size() - 1);
		start <= 1'b0;
	endtask

	task automatic fill_random(int n);
		vec_q.delete();
		repeat (n)
			vec_q.insert(vec_q.size(), pick_elem());
	endtask

	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0 || busy)
			@(negedge clk);
		repeat (8)
			@(negedge clk);
	endtask

	task automatic write_reg(logic idx, int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= POS_W'(val);
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_VECTOR_LENGTH)
			cur_len = val;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		kind = 1'b0;
		element_value = '0;
		last = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_VECTOR_LENGTH;
		cfg_wdata = '0;
		calm = 1'b0;
		n_words = 0;
		cur_len = MAX_DIM;
		repeat (9)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings reject short vectors; then an empty store, a zero
		// vector and a query identical to a stored one.
		fill_random(3);
		send_vec(1'b1);
		send_vec(1'b0);
		drain();
		write_reg(CFG_VECTOR_LENGTH, 4);
		fill_random(4);
		send_vec(1'b1);
		saved_q = vec_q;
		send_vec(1'b0);
		foreach (vec_q[i])
			vec_q[i] = '0;
		send_vec(1'b0);
		vec_q = saved_q;
		send_vec(1'b1);
		foreach (vec_q[i])
			vec_q[i] = -vec_q[i];
		send_vec(1'b1);
		drain();

		write_reg(CFG_VECTOR_LENGTH, 4);
		write_reg(CFG_TOP_K, MAX_TOP_K);
		vec_q = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001};
		send_vec(1'b0);
		send_vec(1'b0);
		vec_q = '{16'h8000, 16'h8000, 16'h8000, 16'h8000};
		send_vec(1'b0);
		send_word(1'b0, 16'h1234, 1'b0);
		send_word(1'b0, 16'hFEDC, 1'b0);
		vec_q = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
		send_vec(1'b1);
		vec_q = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
		send_vec(1'b1);
		vec_q = '{16'h0001, 16'hFFFF, 16'h0002};
		send_vec(1'b1);
		drain();
		write_reg(CFG_TOP_K, 0);
		vec_q = '{16'h0100, 16'h0200, 16'hFF00, 16'h0001};
		send_vec(1'b1);
		drain();
		write_reg(CFG_TOP_K, 1);
		send_vec(1'b1);
		drain();

		// Random traffic: mostly well-formed vectors with random content.
		n_words = 0;
		for (int seg = 0; seg < 4; seg++) begin
			write_reg(CFG_VECTOR_LENGTH, (seg < 2) ? 3 : 2);
			write_reg(CFG_TOP_K, $urandom_range(MAX_TOP_K));
			calm = (seg == 1);
			while (n_words < 26 * (seg + 1)) begin
				if ($urandom_range(99) < 85)
					fill_random(cur_len);
				else
					fill_random($urandom_range(1, 6));
				if ($urandom_range(99) < 10) begin
					vec_q.pop_back();
					for (int i = 0; i < vec_q.size(); i++)
						send_word(1'b0, vec_q[i], 1'b0);
					fill_random(cur_len);
				end
				send_vec($urandom_range(99) < 35);
			end
			drain();
		end
		calm = 1'b0;
		repeat (20)
			@(negedge clk);

		$display("Covered appends %0d, matches %0d, refusals %0d over several settings.",
			n_appends, n_matches, n_refused);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/cts_pkg.sv
hdl/cts_cell.sv
hdl/cts_score.sv
hdl/cosine_top_k_search.sv
hdl/cts_checker.sv
dv/cts_checker.sv
dv/tb_cosine_top_k_search.sv
